>>> rtl/assert_macros.svh
// Assertion macros shared by the traversal RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define BVHRT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define BVHRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/bvhrt_pkg.sv
// Constants, types and arithmetic helpers for the BVH traversal block.
`timescale 1ns / 1ps
package bvhrt_pkg;

  localparam int CAND_LIMIT     = 64;
  localparam int NODE_WORDS     = 16384;
  localparam int LEAF_ENTRIES   = 1024;
  localparam int VISIT_LIMIT    = 4096;
  localparam int STACK_DEPTH    = CAND_LIMIT - 1;

  localparam int NODE_AW  = $clog2(NODE_WORDS);
  localparam int LEAF_AW  = $clog2(LEAF_ENTRIES);
  localparam int SP_W     = $clog2(CAND_LIMIT);
  localparam int CAND_W   = $clog2(CAND_LIMIT + 1);
  localparam int VISIT_W  = $clog2(VISIT_LIMIT + 1);

  // Words fetched per inner node: two boxes of six bounds, then two children.
  localparam int NODE_SPAN = 14;
  localparam int BOUNDS    = 12;
  localparam int WORD_W    = $clog2(NODE_SPAN);
  localparam int DIV_STEPS = 33;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [1:0] KIND_NODE = 2'd0;
  localparam logic [1:0] KIND_LEAF = 2'd1;
  localparam logic [1:0] KIND_RAY  = 2'd2;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ROOT,
    CUR_NEAR,
    CUR_HIT,
    CUR_POP
  } cur_op_t;

  typedef struct packed {
    logic              take;
    logic              div_start;
    logic              div_step;
    logic              div_end;
    logic              mul_setup;
    logic              od_write;
    logic [1:0]        axis;
    logic              node_rd;
    logic [WORD_W-1:0] word;
    logic              visit_init;
    cur_op_t           cur_op;
    logic              push;
    logic              pop_rd;
    logic [SP_W-1:0]   stack_addr;
    logic              leaf_rd;
    logic              emit_leaf;
    logic              emit_final;
    logic              ovf;
  } cmd_t;

  typedef struct packed {
    logic cur_neg;
    logic hit0;
    logic hit1;
    logic out_free;
    logic pend_v;
  } status_t;

  typedef struct packed {
    logic       box;
    logic       hi;
    logic [1:0] axis;
  } slot_t;

  // Placement of a bound word within the node.
  function automatic slot_t slot_of(input logic [WORD_W-1:0] k);
    slot_t s;
    case (k)
      4'd0:    s = '{box: 1'b0, hi: 1'b0, axis: 2'd0};
      4'd1:    s = '{box: 1'b0, hi: 1'b0, axis: 2'd1};
      4'd2:    s = '{box: 1'b0, hi: 1'b0, axis: 2'd2};
      4'd3:    s = '{box: 1'b0, hi: 1'b1, axis: 2'd0};
      4'd4:    s = '{box: 1'b0, hi: 1'b1, axis: 2'd1};
      4'd5:    s = '{box: 1'b0, hi: 1'b1, axis: 2'd2};
      4'd6:    s = '{box: 1'b1, hi: 1'b0, axis: 2'd0};
      4'd7:    s = '{box: 1'b1, hi: 1'b0, axis: 2'd1};
      4'd8:    s = '{box: 1'b1, hi: 1'b0, axis: 2'd2};
      4'd9:    s = '{box: 1'b1, hi: 1'b1, axis: 2'd0};
      4'd10:   s = '{box: 1'b1, hi: 1'b1, axis: 2'd1};
      4'd11:   s = '{box: 1'b1, hi: 1'b1, axis: 2'd2};
      default: s = '{box: 1'b0, hi: 1'b0, axis: 2'd0};
    endcase
    return s;
  endfunction

  // Q16.16 product scaling: floor shift by 16, then saturate to 32 bits.
  function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
    logic [47:0] s;
    logic signed [31:0] r;
    s = p[63:16];
    if ((&s[47:31]) || !(|s[47:31])) begin
      r = s[31:0];
    end else if (s[47]) begin
      r = Q_MIN;
    end else begin
      r = Q_MAX;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    logic signed [31:0] r;
    d = 33'(a) - 33'(b);
    if (d[32] == d[31]) begin
      r = d[31:0];
    end else if (d[32]) begin
      r = Q_MIN;
    end else begin
      r = Q_MAX;
    end
    return r;
  endfunction

endpackage

>>> rtl/bvhrt_dp.sv
// Datapath: memories, reciprocal divider, shared multiplier, slab test and stack.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bvhrt_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  bvhrt_pkg::cmd_t       cmd,
  output bvhrt_pkg::status_t    status,
  input  logic [1:0]            kind,
  input  logic [13:0]           address,
  input  logic [63:0]           load_data,
  input  logic signed [31:0]    origin_x,
  input  logic signed [31:0]    origin_y,
  input  logic signed [31:0]    origin_z,
  input  logic signed [31:0]    dir_x,
  input  logic signed [31:0]    dir_y,
  input  logic signed [31:0]    dir_z,
  input  logic signed [31:0]    near_dist,
  input  logic signed [31:0]    far_dist,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [30:0]           element_id,
  output logic [30:0]           ref_box_id,
  output logic                  found,
  output logic                  last,
  output logic                  stack_overflow
);

  logic [31:0] node_mem [bvhrt_pkg::NODE_WORDS];
  logic [63:0] leaf_mem [bvhrt_pkg::LEAF_ENTRIES];
  logic signed [31:0] stack_mem [bvhrt_pkg::STACK_DEPTH];

  logic [31:0] node_q;
  logic [63:0] leaf_q;
  logic signed [31:0] stack_q;

  logic signed [31:0] origin [3];
  logic signed [31:0] dir [3];
  logic signed [31:0] inv [3];
  logic signed [31:0] od [3];
  logic signed [31:0] tlo [3];
  logic signed [31:0] near_r, far_r;
  logic signed [31:0] e0, e1, l0, l1;
  logic signed [31:0] lc, rc, cur;

  logic [32:0] num, rem, quo;
  logic [31:0] dsor;
  logic [32:0] r_sh;

  logic                         v1, v2;
  logic [bvhrt_pkg::WORD_W-1:0] k1, k2;
  logic signed [63:0]           prod;
  logic signed [31:0]           mul_a, mul_b;
  logic signed [31:0]           t_new, t_min, t_max, inv_res;
  bvhrt_pkg::slot_t             s1, s2;
  logic [bvhrt_pkg::NODE_AW-1:0] node_addr;
  logic                         right_near, hit0, hit1;

  logic [30:0] pend_elem, pend_box;
  logic        pend_v;

  assign s1 = bvhrt_pkg::slot_of(k1);
  assign s2 = bvhrt_pkg::slot_of(k2);
  assign node_addr = cur[bvhrt_pkg::NODE_AW-1:0] + bvhrt_pkg::NODE_AW'(cmd.word);
  assign hit0 = (l0 >= e0);
  assign hit1 = (l1 >= e1);
  assign right_near = (e0 > e1);

  assign status.cur_neg  = cur[31];
  assign status.hit0     = hit0;
  assign status.hit1     = hit1;
  assign status.out_free = !out_valid || out_ready;
  assign status.pend_v   = pend_v;

  // One multiplier serves both the origin term at setup and every box bound.
  assign mul_a = cmd.mul_setup ? origin[cmd.axis] : signed'(node_q);
  assign mul_b = cmd.mul_setup ? inv[cmd.axis] : inv[s1.axis];

  assign t_new = bvhrt_pkg::sub_sat(bvhrt_pkg::qscale(prod), od[s2.axis]);
  assign t_min = (tlo[s2.axis] < t_new) ? tlo[s2.axis] : t_new;
  assign t_max = (tlo[s2.axis] > t_new) ? tlo[s2.axis] : t_new;

  assign r_sh = {rem[31:0], num[32]};

  always_comb begin
    if (dir[cmd.axis] == 32'sd0) begin
      inv_res = bvhrt_pkg::Q_MAX;
    end else if (dir[cmd.axis][31]) begin
      inv_res = (quo > 33'h0_8000_0000) ? bvhrt_pkg::Q_MIN : -signed'(quo[31:0]);
    end else begin
      inv_res = (quo > 33'h0_7FFF_FFFF) ? bvhrt_pkg::Q_MAX : signed'(quo[31:0]);
    end
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (cmd.take && kind == bvhrt_pkg::KIND_NODE) begin
      node_mem[address[bvhrt_pkg::NODE_AW-1:0]] <= load_data[31:0];
    end
    if (cmd.take && kind == bvhrt_pkg::KIND_LEAF &&
        32'(address) < 32'(bvhrt_pkg::LEAF_ENTRIES)) begin
      leaf_mem[address[bvhrt_pkg::LEAF_AW-1:0]] <= load_data;
    end
    if (cmd.node_rd) begin
      node_q <= node_mem[node_addr];
    end
    if (cmd.leaf_rd) begin
      leaf_q <= leaf_mem[~cur[bvhrt_pkg::LEAF_AW-1:0]];
    end
    if (cmd.push) begin
      stack_mem[cmd.stack_addr] <= right_near ? lc : rc;
    end
    if (cmd.pop_rd) begin
      stack_q <= stack_mem[cmd.stack_addr];
    end
  end

  // Ray setup: operands, reciprocal divider and origin terms.
  always_ff @(posedge clk) begin
    if (cmd.take && kind == bvhrt_pkg::KIND_RAY) begin
      origin[0] <= origin_x;
      origin[1] <= origin_y;
      origin[2] <= origin_z;
      dir[0]    <= dir_x;
      dir[1]    <= dir_y;
      dir[2]    <= dir_z;
      near_r    <= near_dist;
      far_r     <= far_dist;
    end
    // Restoring division of 2^32 by the direction magnitude, one bit a cycle.
    if (cmd.div_start) begin
      num  <= 33'h1_0000_0000;
      rem  <= '0;
      quo  <= '0;
      dsor <= dir[cmd.axis][31] ? 32'(-dir[cmd.axis]) : 32'(dir[cmd.axis]);
    end else if (cmd.div_step) begin
      num <= {num[31:0], 1'b0};
      if (r_sh >= {1'b0, dsor}) begin
        rem <= r_sh - {1'b0, dsor};
        quo <= {quo[31:0], 1'b1};
      end else begin
        rem <= r_sh;
        quo <= {quo[31:0], 1'b0};
      end
    end
    if (cmd.div_end) begin
      inv[cmd.axis] <= inv_res;
    end
    if (cmd.od_write) begin
      od[cmd.axis] <= bvhrt_pkg::qscale(prod);
    end
    prod <= mul_a * mul_b;
  end

  // Node pipeline: read, multiply, then slab accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.node_rd;
      v2 <= v1 && (32'(k1) < bvhrt_pkg::BOUNDS);
    end
    k1 <= cmd.word;
    k2 <= k1;
    if (v1 && 32'(k1) == bvhrt_pkg::BOUNDS) begin
      lc <= signed'(node_q);
    end
    if (v1 && 32'(k1) == bvhrt_pkg::BOUNDS + 1) begin
      rc <= signed'(node_q);
    end
    if (cmd.visit_init) begin
      e0 <= near_r;
      e1 <= near_r;
      l0 <= far_r;
      l1 <= far_r;
    end else if (v2) begin
      if (!s2.hi) begin
        tlo[s2.axis] <= t_new;
      end else if (!s2.box) begin
        if (t_min > e0) e0 <= t_min;
        if (t_max < l0) l0 <= t_max;
      end else begin
        if (t_min > e1) e1 <= t_min;
        if (t_max < l1) l1 <= t_max;
      end
    end
  end

  // Current node pointer.
  always_ff @(posedge clk) begin
    case (cmd.cur_op)
      bvhrt_pkg::CUR_ROOT: cur <= '0;
      bvhrt_pkg::CUR_NEAR: cur <= right_near ? rc : lc;
      bvhrt_pkg::CUR_HIT:  cur <= hit0 ? lc : rc;
      bvhrt_pkg::CUR_POP:  cur <= stack_q;
      default:             cur <= cur;
    endcase
  end

  // The newest leaf waits in a holding register until the next one shows
  // whether it is the final beat of the ray.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit_leaf) begin
        pend_v <= 1'b1;
      end else if (cmd.emit_final) begin
        pend_v <= 1'b0;
      end
      if ((cmd.emit_leaf && pend_v) || cmd.emit_final) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (cmd.emit_leaf) begin
      pend_elem <= leaf_q[30:0];
      pend_box  <= leaf_q[62:32];
    end
    if (cmd.emit_leaf && pend_v) begin
      element_id     <= pend_elem;
      ref_box_id     <= pend_box;
      found          <= 1'b1;
      last           <= 1'b0;
      stack_overflow <= 1'b0;
    end else if (cmd.emit_final) begin
      element_id     <= pend_v ? pend_elem : '0;
      ref_box_id     <= pend_v ? pend_box : '0;
      found          <= pend_v;
      last           <= 1'b1;
      stack_overflow <= cmd.ovf;
    end
  end

  `BVHRT_ASSERT_IMP(a_emit_free, (cmd.emit_leaf && pend_v) || cmd.emit_final, !out_valid || out_ready, "result beat overwrote an untaken beat")
  `BVHRT_ASSERT_IMP(a_final_clears, cmd.emit_final, ##1 !pend_v, "holding register not cleared after final beat")

endmodule

>>> rtl/bvhrt_ctrl.sv
// Controller: ray setup sequence and the traversal state machine.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bvhrt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          kind,
  input  bvhrt_pkg::status_t  status,
  output bvhrt_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_INIT,
    S_DIV,
    S_INV,
    S_MUL,
    S_OD,
    S_DISPATCH,
    S_VISIT,
    S_DECIDE,
    S_POP_RD,
    S_POP_WAIT,
    S_LEAF_RD,
    S_LEAF_EMIT,
    S_FINISH
  } state_t;

  state_t                        state;
  logic [1:0]                    axis;
  logic [bvhrt_pkg::CNT_W-1:0]   cnt;
  logic [bvhrt_pkg::SP_W-1:0]    sp;
  logic [bvhrt_pkg::CAND_W-1:0]  cand;
  logic [bvhrt_pkg::VISIT_W-1:0] visits;
  logic                          ovf;

  logic cand_full, visits_out, stack_full, both, none;

  assign cand_full  = (cand == bvhrt_pkg::CAND_W'(bvhrt_pkg::CAND_LIMIT));
  assign visits_out = (visits >= bvhrt_pkg::VISIT_W'(bvhrt_pkg::VISIT_LIMIT));
  assign stack_full = (sp >= bvhrt_pkg::SP_W'(bvhrt_pkg::STACK_DEPTH));
  assign both = status.hit0 && status.hit1;
  assign none = !status.hit0 && !status.hit1;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.cur_op     = bvhrt_pkg::CUR_HOLD;
    cmd.take       = in_ready && in_valid;
    cmd.axis       = axis;
    cmd.word       = cnt[bvhrt_pkg::WORD_W-1:0];
    cmd.stack_addr = (state == S_POP_RD) ? sp - 1'b1 : sp;
    cmd.ovf        = ovf;
    cmd.div_start  = (state == S_DIV_INIT);
    cmd.div_step   = (state == S_DIV);
    cmd.div_end    = (state == S_INV);
    cmd.mul_setup  = (state == S_MUL);
    cmd.od_write   = (state == S_OD);
    cmd.node_rd    = (state == S_VISIT) &&
                     (cnt < bvhrt_pkg::CNT_W'(bvhrt_pkg::NODE_SPAN));
    cmd.visit_init = (state == S_DISPATCH) && !cand_full && !status.cur_neg && !visits_out;
    cmd.push       = (state == S_DECIDE) && both && !stack_full;
    cmd.pop_rd     = (state == S_POP_RD);
    cmd.leaf_rd    = (state == S_LEAF_RD);
    cmd.emit_leaf  = (state == S_LEAF_EMIT) && (!status.pend_v || status.out_free);
    cmd.emit_final = (state == S_FINISH) && status.out_free;
    case (state)
      S_OD:       cmd.cur_op = (axis == 2'd2) ? bvhrt_pkg::CUR_ROOT : bvhrt_pkg::CUR_HOLD;
      S_DECIDE: begin
        if (both && !stack_full) begin
          cmd.cur_op = bvhrt_pkg::CUR_NEAR;
        end else if (!both && !none) begin
          cmd.cur_op = bvhrt_pkg::CUR_HIT;
        end
      end
      S_POP_WAIT: cmd.cur_op = bvhrt_pkg::CUR_POP;
      default:    cmd.cur_op = bvhrt_pkg::CUR_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      axis   <= '0;
      cnt    <= '0;
      sp     <= '0;
      cand   <= '0;
      visits <= '0;
      ovf    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && kind == bvhrt_pkg::KIND_RAY) begin
            state  <= S_DIV_INIT;
            axis   <= '0;
            sp     <= '0;
            cand   <= '0;
            visits <= '0;
            ovf    <= 1'b0;
          end
        end
        S_DIV_INIT: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == bvhrt_pkg::CNT_W'(bvhrt_pkg::DIV_STEPS - 1)) begin
            state <= S_INV;
          end
        end
        S_INV: state <= S_MUL;
        S_MUL: state <= S_OD;
        S_OD: begin
          if (axis == 2'd2) begin
            state <= S_DISPATCH;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_DIV_INIT;
          end
        end
        S_DISPATCH: begin
          if (cand_full) begin
            state <= S_FINISH;
          end else if (status.cur_neg) begin
            state <= S_LEAF_RD;
          end else if (visits_out) begin
            ovf   <= 1'b1;
            state <= S_FINISH;
          end else begin
            visits <= visits + 1'b1;
            cnt    <= '0;
            state  <= S_VISIT;
          end
        end
        S_VISIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == bvhrt_pkg::CNT_W'(bvhrt_pkg::NODE_SPAN)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (none) begin
            state <= (sp == '0) ? S_FINISH : S_POP_RD;
          end else if (both) begin
            if (stack_full) begin
              ovf   <= 1'b1;
              state <= S_FINISH;
            end else begin
              sp    <= sp + 1'b1;
              state <= S_DISPATCH;
            end
          end else begin
            state <= S_DISPATCH;
          end
        end
        S_POP_RD: begin
          sp    <= sp - 1'b1;
          state <= S_POP_WAIT;
        end
        S_POP_WAIT: state <= S_DISPATCH;
        S_LEAF_RD:  state <= S_LEAF_EMIT;
        S_LEAF_EMIT: begin
          if (!status.pend_v || status.out_free) begin
            cand  <= cand + 1'b1;
            state <= (sp == '0) ? S_FINISH : S_POP_RD;
          end
        end
        S_FINISH: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BVHRT_ASSERT(a_sp_bound, sp <= bvhrt_pkg::SP_W'(bvhrt_pkg::STACK_DEPTH), "stack pointer past stack depth")
  `BVHRT_ASSERT(a_cand_bound, cand <= bvhrt_pkg::CAND_W'(bvhrt_pkg::CAND_LIMIT), "candidate count past limit")
  `BVHRT_ASSERT_IMP(a_pop_nonempty, state == S_POP_RD, sp != '0, "pop from an empty stack")

endmodule

>>> rtl/bvh_ray_candidate_traversal.sv
// Top level of the BVH ray candidate traversal block.
`timescale 1ns / 1ps
// Node and leaf loads are written straight into their memories. For each ray,
// setup has a bit-serial divider form the three direction reciprocals in turn;
// then for every inner node visited, the fourteen node words stream through the
// single node memory read port and the shared multiplier. Every leaf reached is
// read from the leaf table, and every stack pop reads the stack memory.
// Results leave in order as leaves are found; the final beat of a ray carries
// last, and stack_overflow when the walk hit the stack depth or the visit limit. No new item is taken
// while a ray is being walked.
module bvh_ray_candidate_traversal (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [13:0]        address,
  input  logic [63:0]        load_data,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic signed [31:0] near_dist,
  input  logic signed [31:0] far_dist,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [30:0]        element_id,
  output logic [30:0]        ref_box_id,
  output logic               found,
  output logic               last,
  output logic               stack_overflow
);

  bvhrt_pkg::cmd_t    cmd;
  bvhrt_pkg::status_t status;

  bvhrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .status   (status),
    .cmd      (cmd)
  );

  bvhrt_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .kind           (kind),
    .address        (address),
    .load_data      (load_data),
    .origin_x       (origin_x),
    .origin_y       (origin_y),
    .origin_z       (origin_z),
    .dir_x          (dir_x),
    .dir_y          (dir_y),
    .dir_z          (dir_z),
    .near_dist      (near_dist),
    .far_dist       (far_dist),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .element_id     (element_id),
    .ref_box_id     (ref_box_id),
    .found          (found),
    .last           (last),
    .stack_overflow (stack_overflow)
  );

endmodule

>>> verif/bvh_ray_candidate_traversal_test.sv
// Testbench for the BVH ray candidate traversal block, with its own traversal predictor.
`timescale 1ns / 1ps
module bvh_ray_candidate_traversal_test;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int  WATCHDOG_LIMIT = 250000;
  localparam int  ONE = 65536;
  localparam int  BIG = 1000 * ONE;
  localparam int  SPAN = 80 * ONE;

  typedef struct {
    logic [1:0]         kind;
    logic [13:0]        address;
    logic [63:0]        load_data;
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] near_d;
    logic signed [31:0] far_d;
  } beat_t;

  typedef struct {
    logic [30:0] elem;
    logic [30:0] box;
    logic        found;
    logic        last;
    logic        ovf;
  } candidate_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic [13:0] address = '0;
  logic [63:0] load_data = '0;
  logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic signed [31:0] near_dist = '0, far_dist = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [30:0] element_id, ref_box_id;
  logic found, last, stack_overflow;

  bvh_ray_candidate_traversal DUT (.*);

  always #4 clk = ~clk;

  // Shadow copies of the node memory and leaf table.
  logic [31:0] node_mem [bvhrt_pkg::NODE_WORDS];
  logic [63:0] leaf_mem [bvhrt_pkg::LEAF_ENTRIES];

  beat_t      pending [$];
  candidate_t cand_q [$];
  beat_t      cur_beat;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit long_hold_req = 1'b0;
  bit long_hold_taken = 1'b0;
  int errors = 0;
  int idle_cycles = 0;
  int rays_traced = 0, results_seen = 0, overflow_rays = 0, full_rays = 0, empty_rays = 0;

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return sat((a * b) >>> 16);
  endfunction

  function automatic longint recip(longint d);
    if (d == 0) return 64'sd2147483647;
    return sat((longint'(1) <<< 32) / d);
  endfunction

  function automatic longint nword(longint base, int k);
    return sx(node_mem[(base + k) % bvhrt_pkg::NODE_WORDS]);
  endfunction

  function automatic bit box_hit(longint base, int off, longint inv [3], longint od [3],
                                 longint lo, longint hi, output longint enter);
    longint e, l, t0, t1;
    e = lo;
    l = hi;
    for (int a = 0; a < 3; a++) begin
      t0 = sat(fx_mul(nword(base, off + a), inv[a]) - od[a]);
      t1 = sat(fx_mul(nword(base, off + 3 + a), inv[a]) - od[a]);
      e = (t0 < t1 ? t0 : t1) > e ? (t0 < t1 ? t0 : t1) : e;
      l = (t0 > t1 ? t0 : t1) < l ? (t0 > t1 ? t0 : t1) : l;
    end
    enter = e;
    return l >= e;
  endfunction

  // Walks the hierarchy for one ray and queues the candidates it yields.
  function automatic void trace_ray(beat_t b);
    longint inv [3], od [3], stk [bvhrt_pkg::CAND_LIMIT];
    longint cur, e0, e1, lc, rc, idx;
    int sp, cand, visits;
    bit done, ovf, h0, h1;
    candidate_t c;
    candidate_t res [$];
    for (int a = 0; a < 3; a++) begin
      inv[a] = recip(sx(b.dir[a]));
      od[a] = fx_mul(sx(b.org[a]), inv[a]);
    end
    cur = 0; sp = 0; cand = 0; visits = 0; done = 0; ovf = 0;
    while (!done && cand < bvhrt_pkg::CAND_LIMIT) begin
      if (cur >= 0) begin
        if (visits >= bvhrt_pkg::VISIT_LIMIT) begin
          ovf = 1;
          break;
        end
        visits++;
        h0 = box_hit(cur, 0, inv, od, sx(b.near_d), sx(b.far_d), e0);
        h1 = box_hit(cur, 6, inv, od, sx(b.near_d), sx(b.far_d), e1);
        if (!h0 && !h1) begin
          if (sp == 0) begin
            done = 1;
          end else begin
            sp = sp - 1;
            cur = stk[sp];
          end
        end else begin
          lc = nword(cur, 12);
          rc = nword(cur, 13);
          if (h0 && h1) begin
            if (sp >= bvhrt_pkg::STACK_DEPTH) begin
              ovf = 1;
              break;
            end
            if (e0 > e1) begin
              stk[sp] = lc;
              cur = rc;
            end else begin
              stk[sp] = rc;
              cur = lc;
            end
            sp = sp + 1;
          end else begin
            cur = h0 ? lc : rc;
          end
        end
      end
      if (!done && cur < 0) begin
        idx = (-(cur + 1)) % bvhrt_pkg::LEAF_ENTRIES;
        c.elem = leaf_mem[idx][30:0];
        c.box = leaf_mem[idx][62:32];
        c.found = 1'b1; c.last = 1'b0; c.ovf = 1'b0;
        res.push_back(c);
        cand++;
        if (sp == 0) begin
          done = 1;
        end else begin
          sp = sp - 1;
          cur = stk[sp];
        end
      end
    end
    if (cand == 0) begin
      c = '{elem: '0, box: '0, found: 1'b0, last: 1'b0, ovf: 1'b0};
      res.push_back(c);
      empty_rays++;
    end
    res[$].last = 1'b1;
    res[$].ovf = ovf;
    if (ovf) overflow_rays++;
    if (cand == bvhrt_pkg::CAND_LIMIT) full_rays++;
    rays_traced++;
    foreach (res[i]) cand_q.push_back(res[i]);
  endfunction

  function automatic void apply_beat(beat_t b);
    case (b.kind)
      bvhrt_pkg::KIND_NODE: node_mem[b.address] = b.load_data[31:0];
      bvhrt_pkg::KIND_LEAF:
        if (b.address < bvhrt_pkg::LEAF_ENTRIES) leaf_mem[b.address] = b.load_data;
      bvhrt_pkg::KIND_RAY:  trace_ray(b);
      default: ;
    endcase
  endfunction

  function automatic beat_t noise_beat(logic [1:0] k);
    beat_t b;
    b.kind = k;
    b.address = 14'($urandom);
    b.load_data = {$urandom, $urandom};
    for (int a = 0; a < 3; a++) begin
      b.org[a] = $urandom;
      b.dir[a] = $urandom;
    end
    b.near_d = $urandom;
    b.far_d = $urandom;
    return b;
  endfunction

  task automatic put_node_word(int addr, logic [31:0] w);
    beat_t b;
    b = noise_beat(bvhrt_pkg::KIND_NODE);
    b.address = 14'(addr);
    b.load_data[31:0] = w;
    pending.push_back(b);
  endtask

  task automatic put_leaf(int idx, logic [63:0] d);
    beat_t b;
    b = noise_beat(bvhrt_pkg::KIND_LEAF);
    b.address = 14'(idx);
    b.load_data = d;
    pending.push_back(b);
  endtask

  task automatic put_ray(int ox, int oy, int oz, int dx, int dy, int dz, int nd, int fd);
    beat_t b;
    b = noise_beat(bvhrt_pkg::KIND_RAY);
    b.org = '{ox, oy, oz};
    b.dir = '{dx, dy, dz};
    b.near_d = nd;
    b.far_d = fd;
    pending.push_back(b);
  endtask

  function automatic int rand_span(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic int rand_dir();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return rand_span(16);
      default: return rand_span(8 * ONE);
    endcase
  endfunction

  // A random tree rooted at word 0, its leaves, then rays, mostly through its region.
  task automatic put_scene(int n, int rays);
    bit claim [bvhrt_pkg::NODE_WORDS];
    int base [6];
    int child [6][2];
    int p, s, ok, lo, idx;
    foreach (claim[i]) claim[i] = 0;
    base[0] = 0;
    for (int w = 0; w < 14; w++) claim[w] = 1;
    for (int i = 1; i < n; i++) begin
      do begin
        if ($urandom_range(0, 5) == 0) base[i] = 16370 + $urandom_range(0, 13);
        else base[i] = $urandom_range(1, 1022) * 16;
        ok = 1;
        for (int w = 0; w < 14; w++)
          if (claim[(base[i] + w) % bvhrt_pkg::NODE_WORDS]) ok = 0;
      end while (!ok);
      for (int w = 0; w < 14; w++) claim[(base[i] + w) % bvhrt_pkg::NODE_WORDS] = 1;
    end
    for (int i = 0; i < n; i++) child[i] = '{-1, -1};
    for (int i = 1; i < n; i++) begin
      do begin
        p = $urandom_range(0, i - 1);
        s = $urandom_range(0, 1);
      end while (child[p][s] >= 0);
      child[p][s] = base[i];
    end
    for (int i = 0; i < n; i++) begin
      for (int c = 0; c < 2; c++) begin
        if (child[i][c] < 0) begin
          idx = $urandom_range(0, bvhrt_pkg::LEAF_ENTRIES - 1);
          put_leaf(idx, {$urandom, $urandom});
          // Leaf indexes past the table wrap around it.
          child[i][c] = -(idx + bvhrt_pkg::LEAF_ENTRIES * $urandom_range(0, 3)) - 1;
        end
      end
      for (int w = 0; w < 12; w++) begin
        if (w % 6 < 3) begin
          lo = rand_span(64 * ONE);
          put_node_word(base[i] + w, lo);
        end else begin
          put_node_word(base[i] + w, lo + $urandom_range(0, 128 * ONE));
        end
      end
      put_node_word((base[i] + 12) % bvhrt_pkg::NODE_WORDS, child[i][0]);
      put_node_word((base[i] + 13) % bvhrt_pkg::NODE_WORDS, child[i][1]);
    end
    put_leaf($urandom_range(bvhrt_pkg::LEAF_ENTRIES, 16383), {$urandom, $urandom});
    pending.push_back(noise_beat(KIND_SPARE));
    for (int r = 0; r < rays; r++) begin
      if ($urandom_range(0, 5) == 0) begin
        pending.push_back(noise_beat(bvhrt_pkg::KIND_RAY));
      end else begin
        put_ray(rand_span(SPAN), rand_span(SPAN), rand_span(SPAN),
                rand_dir(), rand_dir(), rand_dir(),
                $urandom_range(0, 3) == 0 ? -int'($urandom_range(0, 50 * ONE)) : 0,
                $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 200 * ONE))
                                          : bvhrt_pkg::Q_MAX);
      end
    end
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || cand_q.size() > 0) @(posedge clk);
  endtask

  // Input side: offers queued beats and predicts each one as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_beat(cur_beat);
      if (!in_valid || in_ready) begin
        if (pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_beat = pending.pop_front();
          kind <= cur_beat.kind;
          address <= cur_beat.address;
          load_data <= cur_beat.load_data;
          origin_x <= cur_beat.org[0];
          origin_y <= cur_beat.org[1];
          origin_z <= cur_beat.org[2];
          dir_x <= cur_beat.dir[0];
          dir_y <= cur_beat.dir[1];
          dir_z <= cur_beat.dir[2];
          near_dist <= cur_beat.near_d;
          far_dist <= cur_beat.far_d;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: random back-pressure plus a single long hold-off.
  always @(posedge clk) begin
    candidate_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (cand_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected beat: elem=%h box=%h found=%b last=%b ovf=%b",
                     element_id, ref_box_id, found, last, stack_overflow);
        end else begin
          e = cand_q.pop_front();
          if (element_id !== e.elem || ref_box_id !== e.box || found !== e.found ||
              last !== e.last || stack_overflow !== e.ovf) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected elem=%h box=%h found=%b last=%b ovf=%b, got %h %h %b %b %b",
                       e.elem, e.box, e.found, e.last, e.ovf,
                       element_id, ref_box_id, found, last, stack_overflow);
          end
        end
      end
      if (long_hold_req && !long_hold_taken) begin
        hold_left <= 3000;
        long_hold_taken <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", idle_cycles);
      $display("[bvh_ray_candidate_traversal] ERROR");
      $finish;
    end
  end

  initial begin
    foreach (node_mem[i]) node_mem[i] = '0;
    foreach (leaf_mem[i]) leaf_mem[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: one inner node whose boxes cover everything, both children on leaf 0.
    for (int w = 0; w < 12; w++) put_node_word(w, (w % 6 < 3) ? -BIG : BIG);
    put_node_word(12, -1);
    put_node_word(13, -bvhrt_pkg::LEAF_ENTRIES - 1);
    put_leaf(0, '1);
    put_leaf(16383, '0);
    pending.push_back(noise_beat(KIND_SPARE));
    put_ray(0, 0, 0, ONE, ONE, ONE, 0, bvhrt_pkg::Q_MAX);
    put_ray(ONE, 2, -3, 0, 0, 0, bvhrt_pkg::Q_MIN, bvhrt_pkg::Q_MAX);
    put_ray(0, 0, 0, ONE, ONE, ONE, 10 * ONE, -10 * ONE);
    put_ray(bvhrt_pkg::Q_MIN, bvhrt_pkg::Q_MIN, bvhrt_pkg::Q_MIN,
            bvhrt_pkg::Q_MIN, bvhrt_pkg::Q_MIN, bvhrt_pkg::Q_MIN, 0, bvhrt_pkg::Q_MAX);
    put_ray(bvhrt_pkg::Q_MAX, bvhrt_pkg::Q_MAX, bvhrt_pkg::Q_MAX, -1, -1, -1,
            bvhrt_pkg::Q_MIN, bvhrt_pkg::Q_MAX);
    // Right child loops back to the root: the walk repeats until it fills up.
    put_node_word(13, 0);
    put_ray(0, 0, 0, ONE, ONE, ONE, 0, bvhrt_pkg::Q_MAX);
    // Both children loop back, so the stack overflows.
    put_node_word(12, 0);
    put_ray(0, 0, 0, ONE, ONE, ONE, 0, bvhrt_pkg::Q_MAX);
    // Only the looping box is hit: the walk runs until the visit limit.
    put_node_word(6, BIG);
    put_node_word(9, BIG);
    put_ray(0, 0, 0, ONE, ONE, ONE, 0, 0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      @(negedge clk);
      if (ph == 0) long_hold_req = 1'b1;
      put_scene($urandom_range(2, 4), 15);
      // The sender waits here until every pending result has come back.
      drain();
    end
    repeat (300) @(posedge clk);
    if (cand_q.size() > 0) begin
      errors++;
      $display("%0d expected results never arrived", cand_q.size());
    end
    $display("Traced %0d rays into %0d result beats: %0d without a leaf, %0d at the",
             rays_traced, results_seen, empty_rays, full_rays);
    $display("candidate limit, %0d stopped by overflow; %0d mismatches.",
             overflow_rays, errors);
    if (errors == 0) begin
      $display("[bvh_ray_candidate_traversal] OK");
    end else begin
      $display("[bvh_ray_candidate_traversal] ERROR");
    end
    $finish;
  end

endmodule
